### rtl/core/rgb_rle_pkg.sv
package rgb_rle_pkg;

  // Widths of the pixel components and of the run count.
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned COUNT_W = 8;

  // Longest run a single record can carry.
  localparam logic [COUNT_W-1:0] MAX_RUN = '1;

  // Default depth of the record queue, a power of two of at least 2.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One output record.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               final_rec;
  } record_t;

  // Records produced by one pixel transfer, written to the queue in order.
  typedef struct packed {
    logic [1:0] num;
    record_t    first;
    record_t    second;
  } push_t;

endpackage

### rtl/core/rgb_run_length_encoder.sv
// RGB run-length encoder.
// Pixel channel: pixel_valid/pixel_ready with pixel_red, pixel_green,
// pixel_blue and image_end, which marks the last pixel of an image.
// Record channel: record_valid/record_ready with run_count (1 to 255),
// run_red, run_green, run_blue and final_record on the last record.
// A record is emitted when a pixel of a new color arrives, when a run of
// 255 receives one more equal pixel, and on the last pixel, which flushes
// the pending run; that pixel can yield two records.
// A record is written into the record queue by the pixel transfer that
// closes it and is offered from there. Throughput: one pixel per cycle
// while the record queue has room for two records; the front accepts a
// pixel only then, and a double emit fills the queue by two records.
// When the receiver stalls, records collect in the QUEUE_DEPTH-entry queue
// and pixel_ready drops once fewer than two slots are free.
// Reset (synchronous, active high) empties the queue and closes any run.
module rgb_run_length_encoder
  import rgb_rle_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  logic [COLOR_W-1:0] pixel_red,
  input  logic [COLOR_W-1:0] pixel_green,
  input  logic [COLOR_W-1:0] pixel_blue,
  input  logic               image_end,
  output logic               record_valid,
  input  logic               record_ready,
  output logic [COUNT_W-1:0] run_count,
  output logic [COLOR_W-1:0] run_red,
  output logic [COLOR_W-1:0] run_green,
  output logic [COLOR_W-1:0] run_blue,
  output logic               final_record
);

  push_t   push;
  record_t head;
  logic    room;

  assign pixel_ready = room;

  // Front: run tracking and record generation.
  rgb_rle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (pixel_valid && room),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .image_end   (image_end),
    .push        (push)
  );

  // Back: record queue feeding the output channel.
  rgb_rle_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (record_valid),
    .pop        (record_ready),
    .head       (head)
  );

  assign run_count    = head.count;
  assign run_red      = head.red;
  assign run_green    = head.green;
  assign run_blue     = head.blue;
  assign final_record = head.final_rec;

endmodule

### rtl/core/rgb_rle_front.sv
module rgb_rle_front
  import rgb_rle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [COLOR_W-1:0] pixel_red,
  input  logic [COLOR_W-1:0] pixel_green,
  input  logic [COLOR_W-1:0] pixel_blue,
  input  logic               image_end,
  output push_t              push
);

  logic               run_open;
  logic [COUNT_W-1:0] pending_count;
  logic [COLOR_W-1:0] pending_red;
  logic [COLOR_W-1:0] pending_green;
  logic [COLOR_W-1:0] pending_blue;

  logic               run_open_next;
  logic [COUNT_W-1:0] pending_count_next;
  logic [COLOR_W-1:0] pending_red_next;
  logic [COLOR_W-1:0] pending_green_next;
  logic [COLOR_W-1:0] pending_blue_next;

  logic    same_color;
  logic    extend;
  logic    close_old;
  record_t old_rec;
  record_t new_rec;

  // Classify the pixel against the open run.
  always_comb begin
    same_color = (pixel_red == pending_red) && (pixel_green == pending_green) &&
                 (pixel_blue == pending_blue);
    extend     = run_open && same_color && (pending_count != MAX_RUN);
    close_old  = run_open && !extend;

    if (extend) begin
      pending_count_next = pending_count + COUNT_W'(1);
      pending_red_next   = pending_red;
      pending_green_next = pending_green;
      pending_blue_next  = pending_blue;
    end else begin
      pending_count_next = COUNT_W'(1);
      pending_red_next   = pixel_red;
      pending_green_next = pixel_green;
      pending_blue_next  = pixel_blue;
    end
    run_open_next = !image_end;

    old_rec = '{count: pending_count, red: pending_red, green: pending_green,
                blue: pending_blue, final_rec: 1'b0};
    new_rec = '{count: pending_count_next, red: pending_red_next,
                green: pending_green_next, blue: pending_blue_next, final_rec: 1'b1};
  end

  // The closed run goes first; the flushed run follows on the last pixel.
  always_comb begin
    push.num    = 2'd0;
    push.first  = close_old ? old_rec : new_rec;
    push.second = new_rec;
    if (take) begin
      push.num = {1'b0, close_old} + {1'b0, image_end};
    end
  end

  // Run state, cleared after the last pixel of an image.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open      <= 1'b0;
      pending_count <= '0;
    end else if (take) begin
      run_open      <= run_open_next;
      pending_count <= image_end ? '0 : pending_count_next;
    end
    if (take) begin
      pending_red   <= pending_red_next;
      pending_green <= pending_green_next;
      pending_blue  <= pending_blue_next;
    end
  end

endmodule

### rtl/core/rgb_rle_queue.sv
module rgb_rle_queue
  import rgb_rle_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    head_valid,
  input  logic    pop,
  output record_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  record_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_pop;

  // Room for the worst case of two records from one pixel.
  assign room       = (fill <= CNT_W'(DEPTH - 2));
  assign head_valid = (fill != '0);
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr];

  // Storage: up to two writes at consecutive slots.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + CNT_W'(push.num) - CNT_W'(do_pop);
    end
  end

endmodule

### rtl/core/rgb_rle_checker.sv
module rgb_rle_checker
  import rgb_rle_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               pixel_valid,
  input logic               pixel_ready,
  input logic [COLOR_W-1:0] pixel_red,
  input logic [COLOR_W-1:0] pixel_green,
  input logic [COLOR_W-1:0] pixel_blue,
  input logic               image_end,
  input logic               record_valid,
  input logic               record_ready,
  input logic [COUNT_W-1:0] run_count,
  input logic [COLOR_W-1:0] run_red,
  input logic [COLOR_W-1:0] run_green,
  input logic [COLOR_W-1:0] run_blue,
  input logic               final_record
);

  // A stalled record holds its value.
  a_record_hold: assert property (@(posedge clk) disable iff (rst)
    record_valid && !record_ready |=> record_valid &&
      $stable(run_count) && $stable(run_red) && $stable(run_green) &&
      $stable(run_blue) && $stable(final_record))
    else $error("record changed while stalled");

  // Every offered record covers at least one pixel.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    record_valid |-> run_count != '0)
    else $error("record with zero count");

  // Reset leaves no record pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !record_valid)
    else $error("record offered after reset");

  // Backpressure on pixels only comes from records waiting downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> record_valid)
    else $error("pixel stall with empty queue");

  // A final pixel transfer into an idle output must yield a record.
  a_final_follows: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready && image_end && !record_valid |=>
      record_valid)
    else $error("last pixel produced no record");

endmodule

bind rgb_run_length_encoder rgb_rle_checker u_rgb_rle_checker (.*);
